// ===== rtl/postfix_expression_evaluator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shared concurrent assertion shorthands for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PFX_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFX_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Widths, character and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int STACK_DEPTH_DFLT = 64;
  localparam int DATA_W           = 32;
  localparam int CHAR_W           = 8;
  localparam int STATUS_W         = 3;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic ld_char;
    logic ld_digit;
    logic pop;
    logic ld_a;
    logic ld_b;
    logic exec;
    logic div_start;
    logic ld_div;
    logic push;
    logic ld_fin;
    logic emit;
  } pfx_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic a_zero;
    logic last;
    logic div_done;
  } pfx_sts_t;

endpackage

// ===== rtl/pfx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pfx_div.sv =====
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pfx_div import pfx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int SW = $clog2(DATA_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(DATA_W - 1);

  logic              busy;
  logic [SW-1:0]     step;
  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] d;
  logic [DATA_W-1:0] rem;
  logic              neg;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] rem_next;

  assign rem_sh   = {rem, q[DATA_W-1]};
  assign ge       = rem_sh >= {1'b0, d};
  assign rem_next = ge ? DATA_W'(rem_sh - {1'b0, d}) : rem_sh[DATA_W-1:0];
  assign quotient = neg ? (~q + 1'b1) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      d   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      rem <= '0;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[DATA_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/pfx_dp.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack, count, error, operand registers, ALU, divider, result.
// ----------------------------------------------------------------------------
module pfx_dp import pfx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst,
  input  pfx_cmd_t            cmd,
  output pfx_sts_t            sts,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                last_char,
  output logic [DATA_W-1:0]   result_value,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  logic [CHAR_W-1:0]   chr;
  logic                last;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_dec;
  logic [STATUS_W-1:0] err;
  logic                pop_empty;
  logic [DATA_W-1:0]   a_reg;
  logic [DATA_W-1:0]   b_reg;
  logic [DATA_W-1:0]   r_reg;
  logic [DATA_W-1:0]   alu_r;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   div_q;
  logic                div_done;
  logic                full;
  logic [CHAR_W-1:0]   digit;

  assign cnt_dec = cnt - 1'b1;
  assign full    = cnt >= FULL_CNT;
  assign digit   = chr - CH_ZERO;

  pfx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push && !full),
    .waddr (cnt[AW-1:0]),
    .wdata (r_reg),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (rdata)
  );

  pfx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (b_reg),
    .divisor  (a_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (chr)
      CH_MUL:  alu_r = DATA_W'(b_reg * a_reg);
      CH_ADD:  alu_r = b_reg + a_reg;
      CH_SUB:  alu_r = b_reg - a_reg;
      default: alu_r = '0;
    endcase
  end

  assign sts.is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
  assign sts.is_op    = (chr == CH_MUL) || (chr == CH_DIV) ||
                        (chr == CH_ADD) || (chr == CH_SUB);
  assign sts.is_div   = chr == CH_DIV;
  assign sts.a_zero   = a_reg == '0;
  assign sts.last     = last;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      err       <= ST_OK;
      pop_empty <= 1'b0;
    end else begin
      if (cmd.pop) begin
        if (cnt == '0) begin
          pop_empty <= 1'b1;
          if (err == ST_OK) err <= ST_EMPTY;
        end else begin
          pop_empty <= 1'b0;
          cnt       <= cnt_dec;
        end
      end
      if (cmd.exec && sts.is_div && err == ST_OK) begin
        err <= ST_DIVZERO;
      end
      if (cmd.push) begin
        if (full) begin
          if (err == ST_OK) err <= ST_FULL;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.ld_fin && cnt != '0 && err == ST_OK) begin
        err <= ST_LEFTOVER;
      end
      if (cmd.emit) begin
        cnt <= '0;
        err <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_char) begin
      chr  <= char_code;
      last <= last_char;
    end
    if (cmd.ld_a) a_reg <= pop_empty ? '0 : rdata;
    if (cmd.ld_b) b_reg <= pop_empty ? '0 : rdata;
    if (cmd.ld_fin) a_reg <= (pop_empty || cnt != '0) ? '0 : rdata;
    if (cmd.ld_digit) r_reg <= {{(DATA_W - CHAR_W){1'b0}}, digit};
    if (cmd.exec) r_reg <= alu_r;
    if (cmd.ld_div) r_reg <= div_q;
    if (cmd.emit) begin
      result_value <= a_reg;
      status       <= err;
    end
  end

endmodule

// ===== rtl/pfx_ctrl.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences decode, pops, execute, push and result emission.
// ----------------------------------------------------------------------------
module pfx_ctrl import pfx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pfx_sts_t sts,
  output pfx_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DEC  = 12'b000000000010,
    S_POP1 = 12'b000000000100,
    S_LD1  = 12'b000000001000,
    S_POP2 = 12'b000000010000,
    S_LD2  = 12'b000000100000,
    S_EXEC = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_PUSH = 12'b000100000000,
    S_POPF = 12'b001000000000,
    S_LDF  = 12'b010000000000,
    S_EMIT = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_char = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_digit) begin
          cmd.ld_digit = 1'b1;
          state_next   = S_PUSH;
        end else if (sts.is_op) begin
          state_next = S_POP1;
        end else if (sts.last) begin
          state_next = S_POPF;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP1: begin
        cmd.pop    = 1'b1;
        state_next = S_LD1;
      end
      S_LD1: begin
        cmd.ld_a   = 1'b1;
        state_next = S_POP2;
      end
      S_POP2: begin
        cmd.pop    = 1'b1;
        state_next = S_LD2;
      end
      S_LD2: begin
        cmd.ld_b   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_div && !sts.a_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.ld_div = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = sts.last ? S_POPF : S_IDLE;
      end
      S_POPF: begin
        cmd.pop    = 1'b1;
        state_next = S_LDF;
      end
      S_LDF: begin
        cmd.ld_fin = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// RPN evaluator fed one character per transaction; emits value and status.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   in       | in_valid / in_ready  | char_code[7:0], last_char
//   out      | out_valid/ out_ready | result_value[31:0], status[2:0]
//
// Each char is accepted and decoded; digit: push; operator: pop, load, pop, load,
// execute or 32-step divide, push; last_char adds pop, load, emit, held on stall.
// The controller runs one transaction at a time through the stack RAM.
// Reset (rst, synchronous) empties the stack and clears the error; no sweep.
// A pending result is held in the output register while the next char is taken.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_unit_macros.svh"

module postfix_expression_evaluator_unit import pfx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                last_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   result_value,
  output logic [STATUS_W-1:0] status
);

  pfx_cmd_t cmd;
  pfx_sts_t sts;

  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfx_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_value (result_value),
    .status       (status)
  );

  `PFX_ASSERT_IMP(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd), "multiple datapath commands")
  `PFX_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `PFX_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit, out_valid, "emit without out_valid")
  `PFX_ASSERT_IMP(a_div_busy, clk, rst, sts.div_done, !in_ready, "divider done while idle")

endmodule

// ===== test/tb_postfix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Feeds expression characters through the input channel and checks every
// emitted value and status against a cycle-free predictor of the RPN stack.
// A short directed part (- + / operators, empty pops, leftover values, divide
// by zero, first error wins, extreme bytes) is followed by random expressions:
// mostly well-formed formulas, plus broken ones, byte noise, stack overflow
// runs and most-negative divided by minus one. Both channels idle at random,
// and the receiver holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfx_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DFLT;
  localparam int RANDOM_ITEMS = 850;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_item_t;

  typedef struct {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] code;
  } eval_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   char_code = '0;
  logic                last_char = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   result_value;
  logic [STATUS_W-1:0] status;

  char_item_t          char_fifo[$];
  eval_result_t        result_fifo[$];
  logic [CHAR_W-1:0]   expr[$];

  logic [DATA_W-1:0]   calc_stack[DEPTH];
  int unsigned         calc_depth = 0;
  logic [STATUS_W-1:0] calc_err = ST_OK;

  int chars_taken = 0;
  int results_seen = 0;
  int fail_count = 0;
  int active_items = 0;
  int stall_cycles = 0;

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_value(result_value),
    .status      (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void note_err(input logic [STATUS_W-1:0] code);
    if (calc_err == ST_OK) calc_err = code;
  endfunction

  task automatic calc_push(input logic [DATA_W-1:0] v);
    if (calc_depth >= DEPTH) begin
      note_err(ST_FULL);
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endtask

  function automatic logic [DATA_W-1:0] calc_pop();
    if (calc_depth == 0) begin
      note_err(ST_EMPTY);
      return '0;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  task automatic eval_char(input logic [CHAR_W-1:0] ch, input logic last);
    logic [DATA_W-1:0] a, b, r, ma, mb, q;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      calc_push(DATA_W'(ch - CH_ZERO));
    end else if (ch inside {CH_MUL, CH_DIV, CH_ADD, CH_SUB}) begin
      a = calc_pop();
      b = calc_pop();
      case (ch)
        CH_MUL: r = b * a;
        CH_ADD: r = b + a;
        CH_SUB: r = b - a;
        default: begin
          if (a == 0) begin
            note_err(ST_DIVZERO);
            r = '0;
          end else begin
            mb = b[DATA_W-1] ? -b : b;
            ma = a[DATA_W-1] ? -a : a;
            q = mb / ma;
            r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
          end
        end
      endcase
      calc_push(r);
    end
    if (last) begin
      r = calc_pop();
      if (calc_depth != 0) begin
        note_err(ST_LEFTOVER);
        r = '0;
      end
      result_fifo.push_back('{r, calc_err});
      calc_depth = 0;
      calc_err = ST_OK;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr.push_back(s[i]);
  endtask

  task automatic add_formula(input int n);
    int d, pushed, k;
    logic [CHAR_W-1:0] c;
    d = 0;
    pushed = 0;
    while (pushed < n || d > 1) begin
      if ($urandom_range(99) < 8) begin
        c = CHAR_W'($urandom_range(255));
        if (c inside {[CH_ZERO:CH_NINE], CH_MUL, CH_DIV, CH_ADD, CH_SUB}) c = CH_SPACE;
        expr.push_back(c);
      end
      if (pushed < n && (d < 2 || $urandom_range(99) < 50)) begin
        expr.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
        pushed++;
        d++;
      end else begin
        k = $urandom_range(9);
        expr.push_back(k < 4 ? CH_MUL : k < 6 ? CH_DIV : k < 8 ? CH_ADD : CH_SUB);
        d--;
      end
    end
  endtask

  task automatic flush_expr();
    if (expr.size() == 0) expr.push_back(CH_SPACE);
    for (int i = 0; i < expr.size(); i++) begin
      char_fifo.push_back('{expr[i], i == expr.size() - 1});
      if (i == expr.size() - 1 ||
          expr[i] inside {[CH_ZERO:CH_NINE], CH_MUL, CH_DIV, CH_ADD, CH_SUB})
        active_items++;
    end
    expr.delete();
  endtask

  initial begin
    int kind, len, pos, n_expr;

    // directed: operators, truncating divide, error cases, extreme bytes
    add_text("53-");   flush_expr();
    add_text("72/");   flush_expr();
    add_text("80/");   flush_expr();
    add_text("+");     flush_expr();
    add_text("12");    flush_expr();
    add_text("07-2/"); flush_expr();
    expr.push_back(8'hFF); flush_expr();
    expr.push_back(8'h00); add_text(" 4"); flush_expr();
    add_text("9+0/");  flush_expr();

    active_items = 0;
    n_expr = 0;
    while (active_items < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (n_expr == 0) kind = 95;
      if (n_expr == 1) kind = 98;
      len = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
      if (kind < 70) begin
        add_formula(len);
      end else if (kind < 82) begin
        add_formula(len);
        pos = $urandom_range(expr.size() - 1);
        case ($urandom_range(2))
          0: expr.delete(pos);
          1: expr.insert(pos, CH_SUB);
          default: expr.insert(pos, CH_ZERO + CHAR_W'($urandom_range(9)));
        endcase
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 8)) expr.push_back(CHAR_W'($urandom_range(255)));
      end else if (kind < 97) begin
        repeat (DEPTH + $urandom_range(1, 6)) expr.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
        if ($urandom_range(1)) add_text("+*");
      end else begin
        // 8^10 * 2 wraps to the most negative value, then divide by -1
        add_text("8");
        repeat (9) add_text("8*");
        add_text("2*01-/");
      end
      flush_expr();
      n_expr++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (char_fifo.size() != 0 || in_valid || result_fifo.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && result_fifo.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_proc
    char_item_t item;
    bit steady;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        eval_char(char_code, last_char);
        chars_taken++;
      end
      steady = chars_taken >= 300 && chars_taken < 500;
      if (!in_valid || in_ready) begin
        if (char_fifo.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          item = char_fifo.pop_front();
          in_valid  <= 1'b1;
          char_code <= item.ch;
          last_char <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor_proc
    eval_result_t want;
    int hold_left;
    bit hold_done;
    bit steady;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected transaction value=%0d status=%0d",
                   $time, $signed(result_value), status);
          fail_count++;
        end else begin
          want = result_fifo.pop_front();
          if (result_value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, $signed(want.value), $signed(result_value));
            fail_count++;
          end
          if (status !== want.code) begin
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
            fail_count++;
          end
        end
        results_seen++;
      end
      steady = results_seen >= 40 && results_seen < 60;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 13;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/pfx_div.sv
rtl/pfx_dp.sv
rtl/pfx_ctrl.sv
rtl/postfix_expression_evaluator_unit.sv
test/tb_postfix_expression_evaluator_unit.sv
